[rtl/axis_angle_vector_rotate_defines.svh]
// Assertion macros used by the checker of the rotation block.
`ifndef AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define AAVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define AAVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/aavr_pkg.sv]
// Types, constants and the quarter-wave sine table of the axis-angle rotation block.
package aavr_pkg;

  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int COMPONENT_WIDTH    = 16;

  localparam int AXIS_W     = 16;
  localparam int TRIG_W     = 16;
  localparam int ANGLE_W    = 16;
  localparam int PHASE_W    = ANGLE_W - 2;
  localparam int SIN_IDX_W  = $clog2(SINE_TABLE_ENTRIES);
  localparam int SIN_VAL_W  = 15;
  localparam int FRAC_BITS  = 14;
  localparam int ONE_Q14    = 16384;
  localparam int RND_HALF   = 8192;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Reciprocals of the Taylor divisors (2n)(2n+1), scaled by 2^48 and rounded up.
  // Every partial term stays below 2^33, so the scaled product floors exactly.
  localparam int RECIP_SH = 48;
  localparam longint unsigned TAYLOR_RECIP [8] = '{
    ((64'd1 << RECIP_SH) + 64'd5)   / 64'd6,
    ((64'd1 << RECIP_SH) + 64'd19)  / 64'd20,
    ((64'd1 << RECIP_SH) + 64'd41)  / 64'd42,
    ((64'd1 << RECIP_SH) + 64'd71)  / 64'd72,
    ((64'd1 << RECIP_SH) + 64'd109) / 64'd110,
    ((64'd1 << RECIP_SH) + 64'd155) / 64'd156,
    ((64'd1 << RECIP_SH) + 64'd209) / 64'd210,
    ((64'd1 << RECIP_SH) + 64'd271) / 64'd272
  };

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MAX =
    {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MIN =
    {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] vec_x;
    logic signed [COMPONENT_WIDTH-1:0] vec_y;
    logic signed [COMPONENT_WIDTH-1:0] vec_z;
    logic signed [AXIS_W-1:0]          axis_x;
    logic signed [AXIS_W-1:0]          axis_y;
    logic signed [AXIS_W-1:0]          axis_z;
    logic        [ANGLE_W-1:0]         angle;
  } rot_in_t;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] rot_x;
    logic signed [COMPONENT_WIDTH-1:0] rot_y;
    logic signed [COMPONENT_WIDTH-1:0] rot_z;
    logic                              saturated;
  } rot_out_t;

  // A word after the front end: operands plus the looked-up sine and cosine.
  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] vec_x;
    logic signed [COMPONENT_WIDTH-1:0] vec_y;
    logic signed [COMPONENT_WIDTH-1:0] vec_z;
    logic signed [AXIS_W-1:0]          axis_x;
    logic signed [AXIS_W-1:0]          axis_y;
    logic signed [AXIS_W-1:0]          axis_z;
    logic signed [TRIG_W-1:0]          s;
    logic signed [TRIG_W-1:0]          c;
  } rot_job_t;

  typedef logic [SIN_VAL_W-1:0] sin_tab_t [SINE_TABLE_ENTRIES];

  // Taylor series in Q30 up to the x^17 term, then rounded half up to Q1.14.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t          tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    logic [127:0]      prod;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >> SIN_IDX_W;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        prod = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[n-1]);
        term = 64'(prod >> RECIP_SH);
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[k] = SIN_VAL_W'((longint'(sum) + 64'sd32768) >>> 16);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

[rtl/axis_angle_vector_rotate.sv]
// Top level of the axis-angle vector rotation block.
//
//   Channel  Ports                          Word
//   input    in_valid, in_ready, in_data    vector, unit axis, binary angle
//   output   out_valid, out_ready, out_data rotated vector, saturation flag
//
// One word per clock sustained while the output is not stalled; an accepted
// word passes the front register, a queue slot, four arithmetic stages and the
// output register. The throughput is set by the fully pipelined matrix datapath.
// Reset clears every valid flag and the queue; the block is ready in the first
// cycle after reset. A stalled output freezes the arithmetic pipeline while the
// four-word queue and the front register keep taking input until the queue fills.
module axis_angle_vector_rotate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aavr_pkg::rot_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aavr_pkg::rot_out_t out_data
);
  import aavr_pkg::*;

  rot_job_t front_job;
  logic     front_valid;
  logic     front_ready;
  rot_job_t back_job;
  logic     back_valid;
  logic     back_ready;

  aavr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  aavr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_job)
  );

  aavr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .job       (back_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/aavr_front.sv]
// Front end: accepts input words and resolves the angle into sine and cosine.
module aavr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aavr_pkg::rot_in_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output aavr_pkg::rot_job_t job
);
  import aavr_pkg::*;

  quad_t                    quad;
  logic [SIN_IDX_W-1:0]     sin_idx;
  logic [SIN_IDX_W-1:0]     cos_idx;
  logic signed [TRIG_W-1:0] q_lo;
  logic signed [TRIG_W-1:0] q_hi;
  logic signed [TRIG_W-1:0] s_val;
  logic signed [TRIG_W-1:0] c_val;
  rot_job_t                 job_r;
  rot_job_t                 job_nxt;
  logic                     job_valid_r;
  logic                     accept;

  assign quad    = quad_t'(in_data.angle[ANGLE_W-1 -: 2]);
  assign sin_idx = in_data.angle[PHASE_W-1 -: SIN_IDX_W];
  assign cos_idx = '0 - sin_idx;

  // The complementary index reaches the full table size only at phase zero,
  // where the quarter-wave value is exactly one.
  assign q_lo = $signed(TRIG_W'(SIN_TAB[sin_idx]));
  assign q_hi = (sin_idx == '0) ? TRIG_W'(ONE_Q14) : $signed(TRIG_W'(SIN_TAB[cos_idx]));

  always_comb begin
    unique case (quad)
      QUAD_0: begin
        s_val = q_lo;
        c_val = q_hi;
      end
      QUAD_1: begin
        s_val = q_hi;
        c_val = -q_lo;
      end
      QUAD_2: begin
        s_val = -q_lo;
        c_val = -q_hi;
      end
      QUAD_3: begin
        s_val = -q_hi;
        c_val = q_lo;
      end
    endcase
  end

  always_comb begin
    job_nxt.vec_x  = in_data.vec_x;
    job_nxt.vec_y  = in_data.vec_y;
    job_nxt.vec_z  = in_data.vec_z;
    job_nxt.axis_x = in_data.axis_x;
    job_nxt.axis_y = in_data.axis_y;
    job_nxt.axis_z = in_data.axis_z;
    job_nxt.s      = s_val;
    job_nxt.c      = c_val;
  end

  assign in_ready = !job_valid_r || job_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_ready) begin
      job_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

[rtl/aavr_queue.sv]
// Short register queue between the front end and the arithmetic pipeline.
module aavr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  aavr_pkg::rot_job_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output aavr_pkg::rot_job_t pop_data
);
  import aavr_pkg::*;

  rot_job_t          q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/aavr_back.sv]
// Arithmetic pipeline: builds the rotation matrix and applies it to the vector.
module aavr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  aavr_pkg::rot_job_t job,
  output logic               out_valid,
  input  logic               out_ready,
  output aavr_pkg::rot_out_t out_data
);
  import aavr_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int P1_W  = 2 * TRIG_W;
  localparam int SQ_W  = 18;
  localparam int US_W  = 17;
  localparam int OMC_W = 17;
  localparam int DS_W  = SQ_W;
  localparam int PD_W  = TRIG_W + DS_W;
  localparam int PO_W  = SQ_W + OMC_W;
  localparam int M_W   = 19;
  localparam int PR_W  = M_W + CW;
  localparam int ACC_W = PR_W + 2;
  localparam int RW    = ACC_W + 1;

  function automatic logic signed [63:0] rnd_q14(input logic signed [63:0] p);
    return (p + 64'(RND_HALF)) >>> FRAC_BITS;
  endfunction

  logic adv;

  // Stage 1: axis products and the sine terms.
  logic signed [AXIS_W-1:0] u [3];
  logic signed [CW-1:0]     vin [3];
  logic signed [P1_W-1:0]   p_sq_nxt [3];
  logic signed [P1_W-1:0]   p_x_nxt [3];
  logic signed [P1_W-1:0]   p_s_nxt [3];
  logic signed [P1_W-1:0]   p_sq_r [3];
  logic signed [P1_W-1:0]   p_x_r [3];
  logic signed [P1_W-1:0]   p_s_r [3];
  logic signed [TRIG_W-1:0] c1_r;
  logic signed [CW-1:0]     v1_r [3];
  logic                     s1_valid_r;

  // Stage 2: rounded squares and the products with c and 1 - c.
  logic signed [OMC_W-1:0]  omc;
  logic signed [SQ_W-1:0]   sq_nxt [3];
  logic signed [SQ_W-1:0]   uab [3];
  logic signed [DS_W-1:0]   dsub [3];
  logic signed [US_W-1:0]   us_nxt [3];
  logic signed [PD_W-1:0]   q_diag_nxt [3];
  logic signed [PO_W-1:0]   q_off_nxt [3];
  logic signed [SQ_W-1:0]   sq_r [3];
  logic signed [US_W-1:0]   us_r [3];
  logic signed [PD_W-1:0]   q_diag_r [3];
  logic signed [PO_W-1:0]   q_off_r [3];
  logic signed [CW-1:0]     v2_r [3];
  logic                     s2_valid_r;

  // Stage 3: the matrix itself.
  logic signed [M_W-1:0]    off [3];
  logic signed [M_W-1:0]    m_nxt [3][3];
  logic signed [M_W-1:0]    m_r [3][3];
  logic signed [CW-1:0]     v3_r [3];
  logic                     s3_valid_r;

  // Stage 4: the nine matrix-vector products.
  logic signed [PR_W-1:0]   pr_nxt [3][3];
  logic signed [PR_W-1:0]   pr_r [3][3];
  logic                     s4_valid_r;

  // Stage 5: row sums, rounding and clamping into the output register.
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [RW-1:0]     rr [3];
  logic signed [CW-1:0]     comp [3];
  logic [2:0]               clamp;
  rot_out_t                 out_nxt;
  rot_out_t                 out_data_r;
  logic                     out_valid_r;

  // The whole pipeline moves together whenever the output register can take a word.
  assign adv       = !out_valid_r || out_ready;
  assign job_ready = adv;

  always_comb begin
    u[0]   = job.axis_x;
    u[1]   = job.axis_y;
    u[2]   = job.axis_z;
    vin[0] = job.vec_x;
    vin[1] = job.vec_y;
    vin[2] = job.vec_z;
    for (int i = 0; i < 3; i++) begin
      p_sq_nxt[i] = u[i] * u[i];
      p_s_nxt[i]  = u[i] * job.s;
    end
    p_x_nxt[0] = u[0] * u[1];
    p_x_nxt[1] = u[0] * u[2];
    p_x_nxt[2] = u[1] * u[2];
  end

  always_comb begin
    omc = OMC_W'(ONE_Q14) - OMC_W'(c1_r);
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i]     = SQ_W'(rnd_q14(64'(p_sq_r[i])));
      us_nxt[i]     = US_W'(rnd_q14(64'(p_s_r[i])));
      uab[i]        = SQ_W'(rnd_q14(64'(p_x_r[i])));
      dsub[i]       = DS_W'(ONE_Q14) - sq_nxt[i];
      q_diag_nxt[i] = c1_r * dsub[i];
      q_off_nxt[i]  = uab[i] * omc;
    end
  end

  // Off-diagonal pairs share the symmetric part and differ in the sign of the
  // skew part.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i]      = M_W'(rnd_q14(64'(q_off_r[i])));
      m_nxt[i][i] = M_W'(sq_r[i]) + M_W'(rnd_q14(64'(q_diag_r[i])));
    end
    m_nxt[0][1] = off[0] - M_W'(us_r[2]);
    m_nxt[1][0] = off[0] + M_W'(us_r[2]);
    m_nxt[0][2] = off[1] + M_W'(us_r[1]);
    m_nxt[2][0] = off[1] - M_W'(us_r[1]);
    m_nxt[1][2] = off[2] - M_W'(us_r[0]);
    m_nxt[2][1] = off[2] + M_W'(us_r[0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr_nxt[i][j] = m_r[i][j] * v3_r[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(pr_r[i][0]) + ACC_W'(pr_r[i][1]) + ACC_W'(pr_r[i][2]);
      rr[i]  = RW'(rnd_q14(64'(acc[i])));
      if (rr[i] > RW'(COMP_MAX)) begin
        comp[i]  = COMP_MAX;
        clamp[i] = 1'b1;
      end else if (rr[i] < RW'(COMP_MIN)) begin
        comp[i]  = COMP_MIN;
        clamp[i] = 1'b1;
      end else begin
        comp[i]  = CW'(rr[i]);
        clamp[i] = 1'b0;
      end
    end
    out_nxt.rot_x     = comp[0];
    out_nxt.rot_y     = comp[1];
    out_nxt.rot_z     = comp[2];
    out_nxt.saturated = |clamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= job_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r       <= job.c;
      for (int i = 0; i < 3; i++) begin
        p_sq_r[i]   <= p_sq_nxt[i];
        p_x_r[i]    <= p_x_nxt[i];
        p_s_r[i]    <= p_s_nxt[i];
        v1_r[i]     <= vin[i];
        sq_r[i]     <= sq_nxt[i];
        us_r[i]     <= us_nxt[i];
        q_diag_r[i] <= q_diag_nxt[i];
        q_off_r[i]  <= q_off_nxt[i];
        v2_r[i]     <= v1_r[i];
        v3_r[i]     <= v2_r[i];
        for (int j = 0; j < 3; j++) begin
          m_r[i][j]  <= m_nxt[i][j];
          pr_r[i][j] <= pr_nxt[i][j];
        end
      end
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/aavr_checker.sv]
// Port-level checker for the rotation block, bound to its top level.
`include "axis_angle_vector_rotate_defines.svh"

module aavr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input aavr_pkg::rot_in_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input aavr_pkg::rot_out_t out_data
);
  import aavr_pkg::*;

  localparam int CNT_W = 5;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cnt_nxt = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);

  // Words accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `AAVR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `AAVR_ASSERT_IMP(a_no_extra, out_valid, cnt_r != '0, "result word without a pending input word")
  `AAVR_ASSERT_IMP(a_idle_ready, cnt_r == '0, in_ready, "empty block refused an input word")
  `AAVR_ASSERT_IMP(a_sat_limit, out_valid && out_data.saturated, out_data.rot_x == COMP_MAX || out_data.rot_x == COMP_MIN || out_data.rot_y == COMP_MAX || out_data.rot_y == COMP_MIN || out_data.rot_z == COMP_MAX || out_data.rot_z == COMP_MIN, "saturation flagged with no component at a limit")

endmodule

bind axis_angle_vector_rotate aavr_checker u_aavr_checker (.*);
